[sv/lcdns_pkg.sv]
// Shared types, constants and helper functions for the character display
// nibble sequencer. Used by the front end, queue, back end and top level.
// No dependencies.
package lcdns_pkg;

	localparam int MAX_LINE_LENGTH = 40;
	localparam int LEN_W = 6;
	localparam int CNT_W = 7;
	localparam int SETTLE_W = 18;
	localparam int STEP_W = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic CMD_INIT = 1'b0;
	localparam logic CMD_CHAR = 1'b1;

	localparam logic RS_COMMAND = 1'b0;
	localparam logic RS_DATA = 1'b1;

	localparam logic [7:0] BYTE_CLEAR = 8'h01;
	localparam logic [7:0] BYTE_HOME = 8'h80;
	localparam logic [7:0] BYTE_SET_ADDR = 8'h80;

	localparam logic [15:0] WAKE_FIRST_US = 16'd5000;
	localparam logic [15:0] WAKE_SECOND_US = 16'd1000;

	localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(11);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SECOND_LINE_ADDRESS = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STROBE_SETTLE_US = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTE_SETTLE_US = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_SETTLE_US = 3'd4;

	// Bit positions of the pending-byte mask of a message run, lowest first.
	localparam int MB_CLEAR = 0;
	localparam int MB_HOME = 1;
	localparam int MB_LINE2 = 2;
	localparam int MB_CHAR = 3;

	typedef enum logic [2:0] {
		SETTLE_STROBE,
		SETTLE_WAKE_FIRST,
		SETTLE_WAKE_SECOND,
		SETTLE_BYTE,
		SETTLE_CLEAR
	} settle_kind_t;

	typedef struct packed {
		logic       command;
		logic [7:0] char_code;
		logic       first_of_message;
	} in_item_t;

	typedef struct packed {
		logic                reg_select;
		logic [3:0]          nibble;
		logic [SETTLE_W-1:0] settle_us;
		logic                last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] line_length;
		logic [6:0]       second_line_address;
		logic [9:0]       strobe_settle_us;
		logic [15:0]      byte_settle_us;
		logic [15:0]      clear_settle_us;
	} cfg_t;

	// One queued run of strobes, as classified by the front end.
	typedef struct packed {
		logic       is_init;
		logic       do_clear_home;
		logic       do_line2;
		logic       do_char;
		logic [7:0] char_code;
	} run_t;

	typedef struct packed {
		logic [3:0]   nibble;
		settle_kind_t kind;
	} init_step_t;

	// Fixed wake-up, function set, display on, entry mode and clear sequence.
	function automatic init_step_t init_step(input logic [STEP_W-1:0] step);
		init_step_t r;
		case (step)
			4'd0:    r = '{nibble: 4'h3, kind: SETTLE_WAKE_FIRST};
			4'd1:    r = '{nibble: 4'h3, kind: SETTLE_WAKE_SECOND};
			4'd2:    r = '{nibble: 4'h3, kind: SETTLE_STROBE};
			4'd3:    r = '{nibble: 4'h2, kind: SETTLE_STROBE};
			4'd4:    r = '{nibble: 4'h2, kind: SETTLE_STROBE};
			4'd5:    r = '{nibble: 4'h8, kind: SETTLE_BYTE};
			4'd6:    r = '{nibble: 4'h0, kind: SETTLE_STROBE};
			4'd7:    r = '{nibble: 4'hC, kind: SETTLE_BYTE};
			4'd8:    r = '{nibble: 4'h0, kind: SETTLE_STROBE};
			4'd9:    r = '{nibble: 4'h6, kind: SETTLE_BYTE};
			4'd10:   r = '{nibble: 4'h0, kind: SETTLE_STROBE};
			default: r = '{nibble: 4'h1, kind: SETTLE_CLEAR};
		endcase
		return r;
	endfunction

endpackage

[sv/lcdns_front.sv]
// Front end of the nibble sequencer: accepts input items, tracks the cursor
// count and end-of-message flag, and queues one run descriptor per item
// that produces strobes. Depends on lcdns_pkg.
module lcdns_front
	import lcdns_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     q_push,
	output run_t     q_data
);

	logic [CNT_W-1:0] chars_written_q;
	logic             message_ended_q;

	logic [LEN_W-1:0] len_eff;
	logic [CNT_W-1:0] cnt_start;
	logic [CNT_W-1:0] cnt_next;
	logic             ended_start;
	logic             ended_next;
	logic             do_line2;
	logic             do_char;
	logic             is_init;
	logic             accept;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign is_init = (in_data.command == CMD_INIT);

	always_comb begin
		priority if (cfg.line_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (cfg.line_length > LEN_W'(MAX_LINE_LENGTH)) begin
			len_eff = LEN_W'(MAX_LINE_LENGTH);
		end else begin
			len_eff = cfg.line_length;
		end
	end

	always_comb begin
		cnt_start = in_data.first_of_message ? '0 : chars_written_q;
		ended_start = in_data.first_of_message ? 1'b0 : message_ended_q;
		cnt_next = cnt_start;
		ended_next = ended_start;
		do_line2 = 1'b0;
		do_char = 1'b0;
		if (!ended_start) begin
			if (in_data.char_code == 8'h00) begin
				ended_next = 1'b1;
			end else if (cnt_start < {len_eff, 1'b0}) begin
				do_char = 1'b1;
				do_line2 = (cnt_start == CNT_W'(len_eff));
				cnt_next = cnt_start + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_written_q <= '0;
			message_ended_q <= 1'b0;
		end else if (accept) begin
			if (is_init) begin
				chars_written_q <= '0;
				message_ended_q <= 1'b0;
			end else begin
				chars_written_q <= cnt_next;
				message_ended_q <= ended_next;
			end
		end
	end

	// Items that produce no strobes are absorbed here and never queued.
	assign q_push = accept && (is_init || in_data.first_of_message || do_char);

	always_comb begin
		q_data.is_init = is_init;
		q_data.do_clear_home = !is_init && in_data.first_of_message;
		q_data.do_line2 = !is_init && do_line2;
		q_data.do_char = !is_init && do_char;
		q_data.char_code = in_data.char_code;
	end

endmodule

[sv/lcdns_queue.sv]
// Short run-descriptor queue between the front and back ends of the
// nibble sequencer. Depends on lcdns_pkg.
module lcdns_queue
	import lcdns_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t push_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output run_t pop_data
);

	run_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/lcdns_back.sv]
// Back end of the nibble sequencer: expands one queued run into its strobes,
// one per unstalled cycle, into the output register. Depends on lcdns_pkg.
module lcdns_back
	import lcdns_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  run_t      q_data,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic              busy_q;
	logic              is_init_q;
	logic [3:0]        mask_q;
	logic              half_q;
	logic [STEP_W-1:0] step_q;
	logic [7:0]        char_q;
	logic              out_valid_q;
	out_item_t         out_q;

	init_step_t        istep;
	logic [3:0]        sel;
	logic [3:0]        rest;
	logic [7:0]        msg_byte;
	settle_kind_t      kind;
	out_item_t         cur;
	logic              emit;
	logic              finishing;
	logic [SETTLE_W-1:0] s_ext;
	logic [SETTLE_W-1:0] b_ext;
	logic [SETTLE_W-1:0] c_ext;

	assign istep = init_step(step_q);
	assign sel = mask_q & (~mask_q + 4'd1);
	assign rest = mask_q & ~sel;

	always_comb begin
		priority case (1'b1)
			sel[MB_CLEAR]: msg_byte = BYTE_CLEAR;
			sel[MB_HOME]:  msg_byte = BYTE_HOME;
			sel[MB_LINE2]: msg_byte = BYTE_SET_ADDR | {1'b0, cfg.second_line_address};
			default:       msg_byte = char_q;
		endcase
	end

	assign s_ext = SETTLE_W'(cfg.strobe_settle_us);
	assign b_ext = SETTLE_W'(cfg.byte_settle_us);
	assign c_ext = SETTLE_W'(cfg.clear_settle_us);

	always_comb begin
		if (is_init_q) begin
			kind = istep.kind;
			cur.reg_select = RS_COMMAND;
			cur.nibble = istep.nibble;
			cur.last_of_run = (step_q == INIT_LAST_STEP);
		end else begin
			if (!half_q) begin
				kind = SETTLE_STROBE;
			end else if (sel[MB_CLEAR]) begin
				kind = SETTLE_CLEAR;
			end else begin
				kind = SETTLE_BYTE;
			end
			cur.reg_select = sel[MB_CHAR] ? RS_DATA : RS_COMMAND;
			cur.nibble = half_q ? msg_byte[3:0] : msg_byte[7:4];
			cur.last_of_run = half_q && (rest == '0);
		end
		unique case (kind)
			SETTLE_WAKE_FIRST:  cur.settle_us = s_ext + SETTLE_W'(WAKE_FIRST_US);
			SETTLE_WAKE_SECOND: cur.settle_us = s_ext + SETTLE_W'(WAKE_SECOND_US);
			SETTLE_BYTE:        cur.settle_us = s_ext + b_ext;
			SETTLE_CLEAR:       cur.settle_us = s_ext + b_ext + c_ext;
			default:            cur.settle_us = s_ext;
		endcase
	end

	assign emit = busy_q && (!out_valid_q || !out_stall);
	assign finishing = emit && cur.last_of_run;
	// The next run is taken on the cycle the current one sends its last strobe.
	assign q_pop = q_valid && (!busy_q || finishing);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			is_init_q <= 1'b0;
			mask_q <= '0;
			half_q <= 1'b0;
			step_q <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			is_init_q <= q_data.is_init;
			mask_q <= {q_data.do_char, q_data.do_line2,
				q_data.do_clear_home, q_data.do_clear_home};
			half_q <= 1'b0;
			step_q <= '0;
		end else if (finishing) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			if (is_init_q) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				half_q <= !half_q;
				if (half_q) begin
					mask_q <= rest;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			char_q <= q_data.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= cur;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

[sv/char_lcd_nibble_sequencer.sv]
// Top level of the character display nibble sequencer: configuration
// registers plus the front end, run queue and back end.
// Depends on lcdns_pkg, lcdns_front, lcdns_queue and lcdns_back.
//
// Usage: the input channel (in_valid, in_stall, in_data) takes init requests
// and message characters. The output channel (out_valid, out_stall,
// out_data) delivers one nibble strobe per transaction, each with its
// register select, data nibble, settle time in microseconds and a flag on
// the last strobe of the run caused by one input.
// A run's first strobe passes the queue, the back-end run registers and the
// output register. The back end sends one strobe per cycle unless stalled:
// an init run has 12 strobes, a character run 2 to 6; the strobe count per
// run sets the sustained rate. Inputs with no strobes (a zero byte not
// starting a message, characters after the end or past two lines) are taken
// and queue nothing. A four-entry run queue lets new inputs be taken while
// the back end works. When the receiver stalls, the output register holds
// its strobe, the back end waits, and once the queue fills in_stall rises.
// Write configuration through cfg_we/cfg_index/cfg_data only while idle;
// the block does not enforce this. Reset loads the default register values,
// clears the cursor count and end-of-message flag and empties the queue.
module char_lcd_nibble_sequencer
	import lcdns_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data
);

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	run_t q_push_data;
	logic q_pop;
	logic q_valid;
	run_t q_pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_length <= LEN_W'(16);
			cfg_q.second_line_address <= 7'd64;
			cfg_q.strobe_settle_us <= 10'd100;
			cfg_q.byte_settle_us <= 16'd2000;
			cfg_q.clear_settle_us <= 16'd5000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_LENGTH:         cfg_q.line_length <= cfg_data[LEN_W-1:0];
				REG_SECOND_LINE_ADDRESS: cfg_q.second_line_address <= cfg_data[6:0];
				REG_STROBE_SETTLE_US:    cfg_q.strobe_settle_us <= cfg_data[9:0];
				REG_BYTE_SETTLE_US:      cfg_q.byte_settle_us <= cfg_data;
				REG_CLEAR_SETTLE_US:     cfg_q.clear_settle_us <= cfg_data;
				default: ;
			endcase
		end
	end

	lcdns_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_push_data)
	);

	lcdns_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_pop_data)
	);

	lcdns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_pop_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[dv/lcd_strobe_check_pkg.sv]
// Scoreboard for the character display nibble sequencer testbench: keeps its own
// copy of the registers and cursor state, and predicts the strobes of every request.
// Depends on lcdns_pkg for the payload types, register indexes and command bytes.
package lcd_strobe_check_pkg;
	import lcdns_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] FUNCTION_SET_4BIT = 8'h28;
	localparam logic [7:0] DISPLAY_ON = 8'h0C;
	localparam logic [7:0] ENTRY_INCREMENT = 8'h06;
	localparam logic [3:0] WAKE_NIBBLE = 4'h3;
	localparam logic [3:0] BUS_4BIT_NIBBLE = 4'h2;
	localparam int MAX_REPORTS = 100;

	class lcd_strobe_scoreboard;
		logic [LEN_W-1:0] line_length;
		logic [6:0]       line2_addr;
		logic [9:0]       strobe_us;
		logic [15:0]      byte_us;
		logic [15:0]      clear_us;
		int               chars_placed;
		bit               msg_done;
		out_item_t        run_buf[$];
		out_item_t        strobes_due[$];
		int               failures;
		int               runs_with_strobes;

		function new();
			// Register values after reset.
			line_length = 6'd16;
			line2_addr = 7'd64;
			strobe_us = 10'd100;
			byte_us = 16'd2000;
			clear_us = 16'd5000;
			chars_placed = 0;
			msg_done = 1'b0;
			failures = 0;
			runs_with_strobes = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_LINE_LENGTH:         line_length = data[LEN_W-1:0];
				REG_SECOND_LINE_ADDRESS: line2_addr = data[6:0];
				REG_STROBE_SETTLE_US:    strobe_us = data[9:0];
				REG_BYTE_SETTLE_US:      byte_us = data;
				REG_CLEAR_SETTLE_US:     clear_us = data;
				default: ;
			endcase
		endfunction

		function void add_strobe(logic rs, logic [3:0] nib, logic [SETTLE_W-1:0] settle);
			out_item_t s;
			s.reg_select = rs;
			s.nibble = nib;
			s.settle_us = settle;
			s.last_of_run = 1'b0;
			run_buf.push_back(s);
		endfunction

		// A byte goes out high nibble first; the long wait follows the low nibble.
		function void add_byte(logic [7:0] code, logic rs, logic [15:0] extra);
			add_strobe(rs, code[7:4], SETTLE_W'(strobe_us));
			add_strobe(rs, code[3:0], SETTLE_W'(strobe_us) + SETTLE_W'(byte_us)
				+ SETTLE_W'(extra));
		endfunction

		function void note_request(in_item_t req);
			int eff;
			out_item_t tail;
			run_buf.delete();
			if (req.command == CMD_INIT) begin
				add_strobe(RS_COMMAND, WAKE_NIBBLE, SETTLE_W'(strobe_us) + SETTLE_W'(WAKE_FIRST_US));
				add_strobe(RS_COMMAND, WAKE_NIBBLE, SETTLE_W'(strobe_us) + SETTLE_W'(WAKE_SECOND_US));
				add_strobe(RS_COMMAND, WAKE_NIBBLE, SETTLE_W'(strobe_us));
				add_strobe(RS_COMMAND, BUS_4BIT_NIBBLE, SETTLE_W'(strobe_us));
				add_byte(FUNCTION_SET_4BIT, RS_COMMAND, 16'd0);
				add_byte(DISPLAY_ON, RS_COMMAND, 16'd0);
				add_byte(ENTRY_INCREMENT, RS_COMMAND, 16'd0);
				add_byte(BYTE_CLEAR, RS_COMMAND, clear_us);
				chars_placed = 0;
				msg_done = 1'b0;
			end else begin
				eff = int'(line_length);
				if (eff < 1)
					eff = 1;
				if (eff > MAX_LINE_LENGTH)
					eff = MAX_LINE_LENGTH;
				if (req.first_of_message) begin
					add_byte(BYTE_CLEAR, RS_COMMAND, clear_us);
					add_byte(BYTE_HOME, RS_COMMAND, 16'd0);
					chars_placed = 0;
					msg_done = 1'b0;
				end
				if (!msg_done) begin
					if (req.char_code == 8'h00) begin
						msg_done = 1'b1;
					end else if (chars_placed < 2 * eff) begin
						if (chars_placed == eff)
							add_byte(BYTE_SET_ADDR | {1'b0, line2_addr}, RS_COMMAND, 16'd0);
						add_byte(req.char_code, RS_DATA, 16'd0);
						chars_placed++;
					end
				end
			end
			if (run_buf.size() > 0) begin
				tail = run_buf.pop_back();
				tail.last_of_run = 1'b1;
				run_buf.push_back(tail);
				foreach (run_buf[i])
					strobes_due.push_back(run_buf[i]);
				runs_with_strobes++;
			end
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			failures++;
			// Past the cap the count still grows, but the log stays readable.
			if (failures <= MAX_REPORTS)
				$error("%s: expected %0d, actual %0d", field, want, got);
		endfunction

		function void check_strobe(out_item_t got);
			out_item_t want;
			if (strobes_due.size() == 0) begin
				failures++;
				$error("unexpected strobe: reg_select %0d nibble %0d settle_us %0d last_of_run %0d",
					got.reg_select, got.nibble, got.settle_us, got.last_of_run);
				return;
			end
			want = strobes_due.pop_front();
			if (got.reg_select !== want.reg_select)
				report("reg_select", want.reg_select, got.reg_select);
			if (got.nibble !== want.nibble)
				report("nibble", want.nibble, got.nibble);
			if (got.settle_us !== want.settle_us)
				report("settle_us", want.settle_us, got.settle_us);
			if (got.last_of_run !== want.last_of_run)
				report("last_of_run", want.last_of_run, got.last_of_run);
		endfunction

		function int pending();
			return strobes_due.size();
		endfunction
	endclass

endpackage

[dv/testbench.sv]
// Testbench top for char_lcd_nibble_sequencer: directed and random requests under
// random idling and stalls, with every strobe checked against the scoreboard.
// Depends on lcdns_pkg, lcd_strobe_check_pkg and the sequencer RTL.
module testbench;
	import lcdns_pkg::*;
	import lcd_strobe_check_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 20;
	localparam int QUIET_LIMIT = 1000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	in_item_t               in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_item_t              out_data;

	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;
	int quiet_cycles = 0;
	int items_sent = 0;

	lcd_strobe_scoreboard sb = new();

	char_lcd_nibble_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= stall_on && ($urandom_range(99) < 30);
	end

	// Transactions are taken here, at the edge, from the values the DUT saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_request(in_data);
			if (out_valid && !out_stall)
				sb.check_strobe(out_data);
		end
		if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_item(input logic cmd, input logic [7:0] code, input logic first);
		in_item_t item;
		item.command = cmd;
		item.char_code = code;
		item.first_of_message = first;
		if (gaps_on) begin
			while ($urandom_range(99) < 30) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	// Holds the sender off until every predicted strobe has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Bits above each register's width are filled with noise; the block must drop them.
	task automatic write_settings(input int len, input int addr, input int strobe,
		input int byte_wait, input int clear_wait);
		put_reg(REG_LINE_LENGTH, CFG_DATA_W'(len) | (CFG_DATA_W'($urandom) & 16'hFFC0));
		put_reg(REG_SECOND_LINE_ADDRESS, CFG_DATA_W'(addr) | (CFG_DATA_W'($urandom) & 16'hFF80));
		put_reg(REG_STROBE_SETTLE_US, CFG_DATA_W'(strobe) | (CFG_DATA_W'($urandom) & 16'hFC00));
		put_reg(REG_BYTE_SETTLE_US, CFG_DATA_W'(byte_wait));
		put_reg(REG_CLEAR_SETTLE_US, CFG_DATA_W'(clear_wait));
		for (int k = int'(REG_CLEAR_SETTLE_US) + 1; k < 2 ** CFG_INDEX_W; k++)
			put_reg(CFG_INDEX_W'(k), CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic send_message(input int eff_len);
		int n;
		n = $urandom_range(1, 2 * eff_len + 2);
		send_item(CMD_CHAR, 8'($urandom_range(1, 255)), 1'b1);
		for (int i = 1; i < n; i++)
			send_item(CMD_CHAR, 8'($urandom_range(1, 255)), 1'b0);
		if ($urandom_range(1) == 1) begin
			send_item(CMD_CHAR, 8'h00, 1'b0);
			repeat ($urandom_range(2)) send_item(CMD_CHAR, 8'($urandom), 1'b0);
		end
	endtask

	initial begin
		int len;
		int eff;
		int target;
		int pick;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a character before any message start, init with
		// junk fields, a message, its end, and characters after the end.
		send_item(CMD_CHAR, 8'h78, 1'b0);
		send_item(CMD_INIT, 8'hAA, 1'b1);
		send_item(CMD_CHAR, 8'hFF, 1'b1);
		send_item(CMD_CHAR, 8'h01, 1'b0);
		send_item(CMD_CHAR, 8'h80, 1'b0);
		send_item(CMD_CHAR, 8'h00, 1'b0);
		send_item(CMD_CHAR, 8'h41, 1'b0);
		send_item(CMD_CHAR, 8'h00, 1'b1);
		send_item(CMD_CHAR, 8'h42, 1'b0);
		drain();

		// A zero line length acts as one: line change on the second character,
		// then the display is full.
		write_settings(0, 127, 1023, 65535, 65535);
		send_item(CMD_CHAR, 8'h61, 1'b1);
		send_item(CMD_CHAR, 8'h62, 1'b0);
		send_item(CMD_CHAR, 8'h63, 1'b0);
		send_item(CMD_INIT, 8'h55, 1'b0);
		send_item(CMD_CHAR, 8'h7F, 1'b0);
		drain();

		write_settings(63, 0, 0, 0, 0);
		send_item(CMD_CHAR, 8'h5A, 1'b1);
		send_item(CMD_CHAR, 8'h00, 1'b1);

		for (int p = 0; p < 5; p++) begin
			drain();
			case (p)
				0:       len = $urandom_range(1, 4);
				1:       len = $urandom_range(0, 1);
				2:       len = $urandom_range(5, 16);
				3:       len = $urandom_range(40, 63);
				default: len = $urandom_range(0, 63);
			endcase
			write_settings(len, $urandom_range(127), $urandom_range(1023),
				$urandom_range(65535), $urandom_range(65535));
			eff = (len < 1) ? 1 : ((len > MAX_LINE_LENGTH) ? MAX_LINE_LENGTH : len);
			// The first random phase runs with no idling on either side.
			gaps_on = (p != 0);
			stall_on = (p != 0);
			target = items_sent + 24;
			while (items_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 70)
					send_message(eff);
				else if (pick < 80)
					send_item(CMD_INIT, 8'($urandom), 1'($urandom));
				else if (pick < 93)
					send_item(1'($urandom), 8'($urandom), 1'($urandom));
				else
					drain();
			end
		end
		drain();

		if (sb.failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[char_lcd_nibble_sequencer.f]
sv/lcdns_pkg.sv
sv/lcdns_front.sv
sv/lcdns_queue.sv
sv/lcdns_back.sv
sv/char_lcd_nibble_sequencer.sv
dv/lcd_strobe_check_pkg.sv
dv/testbench.sv
